// ===== rtl/rgb_box_filter_downscale_assert.svh =====
// Assertion macros for the RTL of the box filter downscaler.
`ifndef RGB_BOX_FILTER_DOWNSCALE_ASSERT_SVH
`define RGB_BOX_FILTER_DOWNSCALE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RBFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbfd assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RBFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbfd assertion failed");

`endif

// ===== rtl/rbfd_pkg.sv =====
// Shared types and constants of the box filter downscaler.
package rbfd_pkg;

  localparam int CFG_REG_W = 13;
  localparam int ZOOM_REG_W = 7;
  localparam int CFG_ADDR_W = 5;

  localparam logic [2:0] REG_FORMAT_MODE = 3'd0;
  localparam logic [2:0] REG_SRC_WIDTH   = 3'd1;
  localparam logic [2:0] REG_SRC_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_OUT_WIDTH   = 3'd3;
  localparam logic [2:0] REG_OUT_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_ZOOM_FACTOR = 3'd5;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb8_t;

endpackage

// ===== rtl/rgb_box_filter_downscale.sv =====
// An input pixel is accepted in the idle state together with the row store read, then
// accumulated and written back in the accumulate state; a pixel that completes a block
// then waits in the divide state while the divider works out the three means and passes
// its registered done flag, and loads the output register in the output state once that
// register is empty or being taken by the receiver. The row store needs no clearing after
// reset, since each block row's first row overwrites its entries.
`include "rgb_box_filter_downscale_assert.svh"

module rgb_box_filter_downscale
  import rbfd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_ZOOM  = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [55:0]           in_tdata,   // red_in, green_in, blue_in, packed_word
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // red_out, green_out, blue_out
  output logic                  out_tuser,  // row_end
  output logic                  out_tlast,  // image_end
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = AW + 1;
  localparam int ZW    = $clog2(MAX_ZOOM) + 1;
  localparam int SUM_W = 8 + 2 * $clog2(MAX_ZOOM);
  localparam int D_W   = 2 * ZW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic                  fmt_r;
  logic [CFG_REG_W-1:0]  src_w_r, src_h_r, out_w_r, out_h_r;
  logic [ZOOM_REG_W-1:0] zoom_r;
  logic                  cfg_wr;

  logic [CW-1:0] sw, sh, ow, oh;
  logic [ZW-1:0] z;
  logic [D_W-1:0] dsq_r;

  logic [AW-1:0] scol_r, srow_r, bcol_r, brow_r;
  logic [ZW-1:0] cib_r, rib_r;

  logic [1:0]    state_r, state_nxt;
  logic          in_fire, last_col, last_row;
  rgb8_t         px, px_r;
  logic          active_r, first_r, emit_r, row_end_r, image_end_r;
  logic [AW-1:0] addr_r;

  logic [3*SUM_W-1:0] rd_data, wr_data;
  logic               div_done;
  rgb8_t              mean;

  logic        out_valid_r;
  rgb8_t       out_pix_r;
  logic        out_row_end_r, out_image_end_r;
  logic        out_load;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= 1'b0;
      src_w_r <= CFG_REG_W'(1);
      src_h_r <= CFG_REG_W'(1);
      out_w_r <= CFG_REG_W'(1);
      out_h_r <= CFG_REG_W'(1);
      zoom_r  <= ZOOM_REG_W'(1);
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_FORMAT_MODE: fmt_r   <= cfg_pwdata[0];
        REG_SRC_WIDTH:   src_w_r <= cfg_pwdata[CFG_REG_W-1:0];
        REG_SRC_HEIGHT:  src_h_r <= cfg_pwdata[CFG_REG_W-1:0];
        REG_OUT_WIDTH:   out_w_r <= cfg_pwdata[CFG_REG_W-1:0];
        REG_OUT_HEIGHT:  out_h_r <= cfg_pwdata[CFG_REG_W-1:0];
        REG_ZOOM_FACTOR: zoom_r  <= cfg_pwdata[ZOOM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_FORMAT_MODE: cfg_prdata = 32'(fmt_r);
      REG_SRC_WIDTH:   cfg_prdata = 32'(src_w_r);
      REG_SRC_HEIGHT:  cfg_prdata = 32'(src_h_r);
      REG_OUT_WIDTH:   cfg_prdata = 32'(out_w_r);
      REG_OUT_HEIGHT:  cfg_prdata = 32'(out_h_r);
      REG_ZOOM_FACTOR: cfg_prdata = 32'(zoom_r);
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // Effective sizes: zero acts as one, oversized values saturate.
  assign sw = (src_w_r == '0) ? CW'(1) :
              (32'(src_w_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(src_w_r);
  assign sh = (src_h_r == '0) ? CW'(1) :
              (32'(src_h_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(src_h_r);
  assign ow = (out_w_r == '0) ? CW'(1) :
              (32'(out_w_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(out_w_r);
  assign oh = (out_h_r == '0) ? CW'(1) :
              (32'(out_h_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(out_h_r);
  assign z  = (zoom_r == '0) ? ZW'(1) :
              (32'(zoom_r) > MAX_ZOOM) ? ZW'(MAX_ZOOM) : ZW'(zoom_r);

  always_ff @(posedge clk) begin
    dsq_r <= D_W'(z) * D_W'(z);
  end

  // Input side.
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    if (fmt_r) begin
      px.red   = in_tdata[31:24];
      px.green = in_tdata[39:32];
      px.blue  = in_tdata[47:40];
    end else begin
      px.red   = in_tdata[7:0];
      px.green = in_tdata[15:8];
      px.blue  = in_tdata[23:16];
    end
  end

  assign last_col = (32'(cib_r) + 1 >= 32'(z)) || (32'(scol_r) + 1 >= 32'(sw));
  assign last_row = (32'(rib_r) + 1 >= 32'(z)) || (32'(srow_r) + 1 >= 32'(sh));

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r        <= px;
      addr_r      <= bcol_r;
      active_r    <= (32'(bcol_r) < 32'(ow)) && (32'(brow_r) < 32'(oh));
      first_r     <= (cib_r == '0) && (rib_r == '0);
      emit_r      <= last_col && last_row;
      row_end_r   <= (32'(bcol_r) + 1 == 32'(ow));
      image_end_r <= (32'(bcol_r) + 1 == 32'(ow)) && (32'(brow_r) + 1 == 32'(oh));
    end
  end

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      scol_r <= '0;
      srow_r <= '0;
      bcol_r <= '0;
      brow_r <= '0;
      cib_r  <= '0;
      rib_r  <= '0;
    end else if (in_fire) begin
      if (32'(scol_r) + 1 >= 32'(sw)) begin
        scol_r <= '0;
        cib_r  <= '0;
        bcol_r <= '0;
        if (32'(srow_r) + 1 >= 32'(sh)) begin
          srow_r <= '0;
          rib_r  <= '0;
          brow_r <= '0;
        end else begin
          srow_r <= srow_r + AW'(1);
          if (32'(rib_r) + 1 >= 32'(z)) begin
            rib_r  <= '0;
            brow_r <= brow_r + AW'(1);
          end else begin
            rib_r <= rib_r + ZW'(1);
          end
        end
      end else begin
        scol_r <= scol_r + AW'(1);
        if (32'(cib_r) + 1 >= 32'(z)) begin
          cib_r  <= '0;
          bcol_r <= bcol_r + AW'(1);
        end else begin
          cib_r <= cib_r + ZW'(1);
        end
      end
    end
  end

  // Read-modify-write of the row store; the first row of a block row overwrites.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (first_r) begin
        wr_data[c*SUM_W +: SUM_W] = SUM_W'(px_r[c*8 +: 8]);
      end else begin
        wr_data[c*SUM_W +: SUM_W] = rd_data[c*SUM_W +: SUM_W] + SUM_W'(px_r[c*8 +: 8]);
      end
    end
  end

  rbfd_sum_ram #(
    .AW (AW),
    .DW (3 * SUM_W)
  ) u_ram (
    .clk   (clk),
    .we    (state_r == ST_ACC && active_r),
    .waddr (addr_r),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (bcol_r),
    .rdata (rd_data)
  );

  rbfd_div #(
    .SUM_W (SUM_W),
    .D_W   (D_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_ACC && active_r && emit_r),
    .sums  (wr_data),
    .dsq   (dsq_r),
    .done  (div_done),
    .mean  (mean)
  );

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (active_r && emit_r) ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r       <= mean;
      out_row_end_r   <= row_end_r;
      out_image_end_r <= image_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_row_end_r;
  assign out_tlast  = out_image_end_r;

  `RBFD_ASSERT_NOW(a_no_accept_while_dividing, state_r == ST_DIV, !in_tready)
  `RBFD_ASSERT_NEXT(a_cfg_restarts_frame, cfg_wr, scol_r == '0 && srow_r == '0 && bcol_r == '0)
  `RBFD_ASSERT_NEXT(a_emit_starts_divide, state_r == ST_ACC && active_r && emit_r,
                    state_r == ST_DIV)

endmodule

// ===== rtl/rbfd_sum_ram.sv =====
// Row store of per-block channel sums: one write port, one registered read port.
module rbfd_sum_ram #(
  parameter int AW = 12,
  parameter int DW = 60
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rbfd_div.sv =====
// Radix-2 divider producing the three rounded block means, one quotient bit a cycle.
module rbfd_div
  import rbfd_pkg::*;
#(
  parameter int SUM_W = 20,
  parameter int D_W   = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [3*SUM_W-1:0] sums,
  input  logic [D_W-1:0]     dsq,
  output logic               done,
  output rgb8_t              mean
);

  localparam int RW = SUM_W + 2;

  logic [RW-1:0] rem_r [3];
  logic [RW-1:0] rem_nxt [3];
  logic [7:0]    q_r [3];
  logic [7:0]    q_nxt [3];
  logic [RW-1:0] den_r, den_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    for (int c = 0; c < 3; c++) begin
      rem_nxt[c] = rem_r[c];
      q_nxt[c]   = q_r[c];
    end
    if (start) begin
      // Rounded half up: (2*sum + d) / (2*d), with 2*d pre-shifted by seven.
      for (int c = 0; c < 3; c++) begin
        rem_nxt[c] = RW'({sums[c*SUM_W +: SUM_W], 1'b0}) + RW'(dsq);
        q_nxt[c]   = 8'd0;
      end
      den_nxt  = RW'(dsq) << 8;
      cnt_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int c = 0; c < 3; c++) begin
        if (rem_r[c] >= den_r) begin
          rem_nxt[c] = rem_r[c] - den_r;
          q_nxt[c]   = {q_r[c][6:0], 1'b1};
        end else begin
          q_nxt[c]   = {q_r[c][6:0], 1'b0};
        end
      end
      den_nxt = den_r >> 1;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    for (int c = 0; c < 3; c++) begin
      rem_r[c] <= rem_nxt[c];
      q_r[c]   <= q_nxt[c];
    end
  end

  assign done       = done_r;
  assign mean.red   = q_r[0];
  assign mean.green = q_r[1];
  assign mean.blue  = q_r[2];

endmodule

// ===== bench/rgb_box_filter_downscale_tb.sv =====
// Self-checking testbench of the RGB box filter downscaler: stream stimulus and scoreboard.
`timescale 1ns / 100ps

module rgb_box_filter_downscale_tb;
  import rbfd_pkg::*;

  localparam int PIX_MAX_WIDTH = 4096;
  localparam int PIX_MAX_ZOOM  = 64;
  localparam int STALL_LIMIT   = 40000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int ITEM_TARGET   = 1300;
  localparam logic [2:0] REG_UNUSED = 3'd6;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic       image_end;
  } mean_pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // red_in, green_in, blue_in, packed_word
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // red_out, green_out, blue_out
  logic        out_tuser;  // row_end
  logic        out_tlast;  // image_end
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rgb_box_filter_downscale u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Shadow registers and position counters of the reduction.
  logic [12:0] fmt_reg, sw_reg, sh_reg, ow_reg, oh_reg, zoom_reg;
  int unsigned src_col, src_row, col_in_blk, row_in_blk, blk_col, blk_row;
  logic [31:0] row_sums [PIX_MAX_WIDTH][3];

  logic [55:0] pixel_queue[$];
  mean_pixel_t mean_queue[$];
  int          mismatches;
  int          items_pushed;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_trig;
  int          hold_seen;
  int          hold_left;
  int          quiet_cycles;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic void restart_frame();
    src_col = 0; src_row = 0; col_in_blk = 0; row_in_blk = 0; blk_col = 0; blk_row = 0;
  endfunction

  // Accumulates one source pixel into the row sums and queues the block mean it completes.
  function automatic void accumulate_pixel(logic [55:0] d);
    int unsigned sw, sh, ow, oh, z, dv;
    logic [7:0]  px [3];
    logic        last_col, last_row;
    mean_pixel_t m;
    sw = clamp_size(sw_reg, PIX_MAX_WIDTH);
    sh = clamp_size(sh_reg, PIX_MAX_WIDTH);
    ow = clamp_size(ow_reg, PIX_MAX_WIDTH);
    oh = clamp_size(oh_reg, PIX_MAX_WIDTH);
    z  = clamp_size(zoom_reg, PIX_MAX_ZOOM);
    if (fmt_reg[0]) begin
      px[0] = d[31:24]; px[1] = d[39:32]; px[2] = d[47:40];
    end else begin
      px[0] = d[7:0]; px[1] = d[15:8]; px[2] = d[23:16];
    end
    last_col = (col_in_blk + 1 >= z) || (src_col + 1 >= sw);
    last_row = (row_in_blk + 1 >= z) || (src_row + 1 >= sh);
    if (blk_col < ow && blk_row < oh && blk_col < PIX_MAX_WIDTH) begin
      for (int c = 0; c < 3; c++) begin
        if (row_in_blk == 0 && col_in_blk == 0) row_sums[blk_col][c] = px[c];
        else row_sums[blk_col][c] = row_sums[blk_col][c] + px[c];
      end
      if (last_col && last_row) begin
        dv = z * z;
        m.red   = 8'((2 * row_sums[blk_col][0] + dv) / (2 * dv));
        m.green = 8'((2 * row_sums[blk_col][1] + dv) / (2 * dv));
        m.blue  = 8'((2 * row_sums[blk_col][2] + dv) / (2 * dv));
        m.row_end   = (blk_col + 1 == ow);
        m.image_end = m.row_end && (blk_row + 1 == oh);
        mean_queue.push_back(m);
      end
    end
    if (src_col + 1 >= sw) begin
      src_col = 0; col_in_blk = 0; blk_col = 0;
      if (src_row + 1 >= sh) begin
        src_row = 0; row_in_blk = 0; blk_row = 0;
      end else begin
        src_row++;
        if (row_in_blk + 1 >= z) begin
          row_in_blk = 0; blk_row++;
        end else begin
          row_in_blk++;
        end
      end
    end else begin
      src_col++;
      if (col_in_blk + 1 >= z) begin
        col_in_blk = 0; blk_col++;
      end else begin
        col_in_blk++;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Driver: presents queued pixels and predicts on every input transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) accumulate_pixel(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with an occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_seen  <= 0;
    end else if (hold_seen != hold_trig) begin
      hold_seen  <= hold_trig;
      hold_left  <= 600;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    mean_pixel_t m;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (mean_queue.size() == 0) begin
          report_mismatch("result transfer count", 1, 0);
        end else begin
          m = mean_queue.pop_front();
          if (out_tdata[7:0] !== m.red) report_mismatch("red", out_tdata[7:0], m.red);
          if (out_tdata[15:8] !== m.green) report_mismatch("green", out_tdata[15:8], m.green);
          if (out_tdata[23:16] !== m.blue) report_mismatch("blue", out_tdata[23:16], m.blue);
          if (out_tuser !== m.row_end) report_mismatch("row_end", out_tuser, m.row_end);
          if (out_tlast !== m.image_end) report_mismatch("image_end", out_tlast, m.image_end);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (pixel_queue.size() == 0 && mean_queue.size() == 0 && !in_tvalid)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_FORMAT_MODE: fmt_reg  = 13'(val[0]);
      REG_SRC_WIDTH:   sw_reg   = val[12:0];
      REG_SRC_HEIGHT:  sh_reg   = val[12:0];
      REG_OUT_WIDTH:   ow_reg   = val[12:0];
      REG_OUT_HEIGHT:  oh_reg   = val[12:0];
      REG_ZOOM_FACTOR: zoom_reg = 13'(val[6:0]);
      default: ;
    endcase
    restart_frame();
  endtask

  // Waits until every pixel is in and every mean is out, then lets the pipeline settle.
  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_tvalid || mean_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int fm, int sw, int sh, int ow, int oh, int z);
    wait_drained();
    reg_write(REG_FORMAT_MODE, fm);
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_OUT_WIDTH, ow);
    reg_write(REG_OUT_HEIGHT, oh);
    reg_write(REG_ZOOM_FACTOR, z);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) pixel_queue.push_back(56'({$urandom, $urandom}));
    items_pushed += n;
  endtask

  task automatic pick_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
  endtask

  initial begin
    int sw, sh, z, ow, oh, phase;
    rst_n = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    mismatches = 0; items_pushed = 0; quiet_cycles = 0;
    hold_trig = 0; send_idle_pct = 0; recv_stall_pct = 0;
    fmt_reg = 0; sw_reg = 1; sh_reg = 1; ow_reg = 1; oh_reg = 1; zoom_reg = 1;
    restart_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: one pixel per image, passed straight through.
    pixel_queue.push_back(56'h0);
    pixel_queue.push_back(56'h00_0000_00FF_FFFF);
    // Byte channels, 2x2 blocks, extremes of every byte.
    configure(0, 4, 2, 2, 1, 2);
    pixel_queue.push_back(56'h0);
    pixel_queue.push_back(56'h00_0000_00FF_FFFF);
    pixel_queue.push_back(56'h00_0000_00FF_FFFF);
    pixel_queue.push_back(56'h0);
    pixel_queue.push_back(56'h00_0000_00FF_FFFF);
    pixel_queue.push_back(56'h00_0000_00FF_FFFF);
    pixel_queue.push_back(56'h0);
    pixel_queue.push_back(56'h00_0000_0001_0203);
    // Packed words, partial blocks at the edges, spare byte set.
    configure(1, 3, 3, 2, 2, 2);
    pixel_queue.push_back(56'hFF_FFFF_FF00_0000);
    pixel_queue.push_back(56'h00_0000_0000_0000);
    pixel_queue.push_back(56'hFF_00FF_0000_0000);
    push_random(6);
    // Zero sizes act as one; output width beyond the source leaves row_end unsignalled.
    configure(0, 0, 0, 3, 0, 0);
    push_random(2);
    configure(1, 3, 1, 3, 1, 2);
    push_random(5);
    // Frame restart from a register write that hits no register.
    configure(0, 4, 4, 1, 1, 2);
    push_random(3);
    wait_drained();
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    push_random(6);

    // Largest block, largest and oversized source sizes; a partial row is cut off by the
    // next register write.
    pick_idling(0);
    configure(1, 64, 2, 1, 1, 64);
    push_random(128);
    configure(0, 4096, 1, 64, 1, 64);
    push_random(640);
    // Long receiver hold-off while the sender keeps offering pixels.
    hold_trig = hold_trig + 1;
    configure(1, 1, 8191, 1, 8191, 127);
    push_random(256);

    phase = 0;
    while (items_pushed < ITEM_TARGET || phase < 8) begin
      z  = ($urandom_range(9) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 5);
      sw = $urandom_range(1, (z > 8) ? 2 * z : 24);
      sh = $urandom_range(1, (z > 8) ? 2 : 10);
      ow = $urandom_range(1, (sw + z - 1) / z);
      oh = $urandom_range(1, (sh + z - 1) / z);
      configure($urandom_range(1), sw, sh, ow, oh, z);
      pick_idling(phase);
      push_random(sw * sh * $urandom_range(1, 2));
      if (phase == 5) hold_trig = hold_trig + 1;
      phase++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
